@@ design/cbm_pkg.sv @@
// cbm_pkg: shared types, constants and helpers for the cartridge bank mapper
// no dependencies; used by the interfaces, the RAM and the top level
`default_nettype none

package cbm_pkg;

  // banked RAM geometry
  localparam int RAM_BYTES = 32768;
  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam logic [15:0] RAM_BYTES_W = 16'(RAM_BYTES);
  localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_BYTES - 1);
  localparam logic [7:0] RAM_FILL = 8'hFF;

  // field widths
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int KIND_W = 3;
  localparam int ROM_AW = 20;
  localparam int ROMB_W = 6;
  localparam int RAMB_W = 2;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_MASK = 1'd1;
  localparam logic [ROMB_W-1:0] ROM_MASK_RST = 6'h3F;
  localparam logic [RAMB_W-1:0] RAM_MASK_RST = 2'h3;

  // bus opcodes
  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // address regions, top three address bits
  localparam logic [2:0] RGN_MODE = 3'd0;
  localparam logic [2:0] RGN_ROMB = 3'd1;
  localparam logic [2:0] RGN_RAMB = 3'd2;
  localparam logic [2:0] RGN_IGN = 3'd3;
  localparam logic [2:0] RGN_RAM = 3'd5;

  localparam logic [3:0] IR_NIBBLE = 4'hE;
  localparam logic [7:0] IR_READ_VAL = 8'hC0;
  localparam logic [ROMB_W-1:0] ROMB_RST = 6'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ROM_READ  = 3'd0,
    KIND_RAM_READ  = 3'd1,
    KIND_FWD_READ  = 3'd2,
    KIND_FWD_WRITE = 3'd3,
    KIND_ABSORB    = 3'd4
  } cbm_kind_t;

  // one request to the banked RAM; read and write never share a cycle
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic [RAM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } cbm_ram_req_t;

  // bank * 0x2000 + offset, wrapped into the RAM size
  function automatic logic [RAM_AW-1:0] ram_wrap(input logic [14:0] raw);
    logic [15:0] v;
    v = {1'b0, raw};
    for (int i = 0; i < 4; i++) begin
      if (v >= RAM_BYTES_W) begin
        v = v - RAM_BYTES_W;
      end
    end
    return v[RAM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/cbm_if.sv @@
// cbm_in_if / cbm_out_if: valid/ready channels for bus accesses and results
// depends on cbm_pkg for the field widths
`default_nettype none

interface cbm_in_if;
  import cbm_pkg::*;
  logic valid;
  logic ready;
  logic opcode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source(output valid, opcode, address, write_data, input ready);
  modport sink(input valid, opcode, address, write_data, output ready);
endinterface

interface cbm_out_if;
  import cbm_pkg::*;
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [ROM_AW-1:0] rom_address;
  logic [DATA_W-1:0] read_data;
  logic [ADDR_W-1:0] forward_address;
  logic [DATA_W-1:0] forward_data;

  modport source(output valid, kind, rom_address, read_data, forward_address,
                 forward_data, input ready);
  modport sink(input valid, kind, rom_address, read_data, forward_address,
               forward_data, output ready);
endinterface

`default_nettype wire

@@ design/cbm_bank_ram.sv @@
// cbm_bank_ram: banked cartridge RAM, registered read, fill after reset
// depends on cbm_pkg
`default_nettype none

module cbm_bank_ram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cbm_pkg::cbm_ram_req_t       req,
  output logic [cbm_pkg::DATA_W-1:0]       rd_data,
  output logic                             busy
);
  import cbm_pkg::*;

  logic [DATA_W-1:0] mem [RAM_BYTES];
  logic [DATA_W-1:0] rd_data_r;
  logic [RAM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clearing_r, clearing_nxt;

  // fill sweep, one byte a cycle
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == RAM_LAST) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= RAM_FILL;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy = clearing_r;

endmodule

`default_nettype wire

@@ design/cartridge_bank_mapper_ir_top.sv @@
// cartridge_bank_mapper_ir_top: cartridge bank mapper with infrared stub
// depends on cbm_pkg, cbm_in_if / cbm_out_if and cbm_bank_ram
`default_nettype none

// usage
//   in_ch carries one cpu bus transaction: opcode (0 read, 1 write), address
//   and write_data. out_ch returns exactly one result transaction per input:
//   kind, rom_address, read_data, forward_address, forward_data, with fields
//   that do not apply to the kind driven to zero.
//   cfg_we/cfg_index/cfg_wdata write the rom and ram bank masks; write them
//   only while no transaction is in flight.
// timing
//   a transaction is decoded, and its ram read done, at the accept edge into
//   the decode stage; it then moves on to the output register when that is
//   free. one transaction per cycle is sustained while out_ch.ready stays
//   high: the ram has one port and each access uses it once, reads registered,
//   so a ram write is seen by a read in the next cycle without forwarding.
// reset
//   rst_n (synchronous, active low) restores bank registers and masks and
//   starts a fill of the banked ram with 0xff, one byte per cycle: in_ch.ready
//   stays low until the fill is done. cfg writes are taken throughout.
// back pressure
//   when out_ch.ready is low the result holds; one more transaction can wait
//   in the decode stage, after which in_ch.ready drops.

module cartridge_bank_mapper_ir_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  cbm_in_if.sink                               in_ch,
  cbm_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cbm_pkg::*;

  // mapper state and configuration
  logic [ROMB_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAMB_W-1:0] ram_bank_r, ram_bank_nxt;
  logic              ir_r, ir_nxt;
  logic [ROMB_W-1:0] rom_mask_r;
  logic [RAMB_W-1:0] ram_mask_r;

  // decode stage
  logic              s1_valid_r;
  cbm_kind_t         s1_kind_r;
  logic [ROM_AW-1:0] s1_rom_addr_r;
  logic [ADDR_W-1:0] s1_faddr_r;
  logic [DATA_W-1:0] s1_fdata_r;
  logic              s1_ram_rd_r;
  logic              s1_ir_rd_r;

  // output register
  logic              out_valid_r;
  cbm_kind_t         out_kind_r;
  logic [ROM_AW-1:0] out_rom_addr_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [ADDR_W-1:0] out_faddr_r;
  logic [DATA_W-1:0] out_fdata_r;

  // decode of the incoming transaction
  logic              accept;
  logic              advance;
  logic [2:0]        region;
  cbm_kind_t         dec_kind;
  logic [ROM_AW-1:0] dec_rom_addr;
  logic [ADDR_W-1:0] dec_faddr;
  logic [DATA_W-1:0] dec_fdata;
  logic              dec_ram_rd;
  logic              dec_ir_rd;

  cbm_ram_req_t      ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              ram_busy;

  assign advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !ram_busy && (!s1_valid_r || advance);
  assign accept = in_ch.valid && in_ch.ready;
  assign region = in_ch.address[15:13];

  always_comb begin
    dec_kind = KIND_ABSORB;
    dec_rom_addr = '0;
    dec_faddr = '0;
    dec_fdata = '0;
    dec_ram_rd = 1'b0;
    dec_ir_rd = 1'b0;
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ir_nxt = ir_r;
    ram_req.wr_en = 1'b0;
    ram_req.rd_en = 1'b0;
    ram_req.addr = ram_wrap({ram_bank_r, in_ch.address[12:0]});
    ram_req.wdata = in_ch.write_data;

    if (in_ch.opcode == OP_WRITE) begin
      case (region)
        RGN_MODE: ir_nxt = (in_ch.write_data[3:0] == IR_NIBBLE);
        RGN_ROMB: rom_bank_nxt = in_ch.write_data[ROMB_W-1:0] & rom_mask_r;
        RGN_RAMB: ram_bank_nxt = in_ch.write_data[RAMB_W-1:0] & ram_mask_r;
        RGN_IGN: ;
        // ram writes are dropped while infrared mode is on
        RGN_RAM: ram_req.wr_en = accept && !ir_r;
        default: begin
          dec_kind = KIND_FWD_WRITE;
          dec_faddr = in_ch.address;
          dec_fdata = in_ch.write_data;
        end
      endcase
    end else begin
      case (region)
        RGN_RAMB, RGN_IGN: begin
          // bank * 0x4000 + (address - 0x4000)
          dec_kind = KIND_ROM_READ;
          dec_rom_addr = {rom_bank_r, in_ch.address[13:0]};
        end
        RGN_RAM: begin
          dec_kind = KIND_RAM_READ;
          dec_ram_rd = !ir_r;
          dec_ir_rd = ir_r;
          ram_req.rd_en = accept && !ir_r;
        end
        default: begin
          dec_kind = KIND_FWD_READ;
          dec_faddr = in_ch.address;
        end
      endcase
    end
  end

  cbm_bank_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_rdata),
    .busy    (ram_busy)
  );

  // mapper registers, updated at the accept edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= ROMB_RST;
      ram_bank_r <= '0;
      ir_r <= 1'b0;
    end else if (accept) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      ir_r <= ir_nxt;
    end
  end

  // bank masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_mask_r <= ROM_MASK_RST;
      ram_mask_r <= RAM_MASK_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROM_MASK) begin
        rom_mask_r <= cfg_wdata[ROMB_W-1:0];
      end else if (cfg_index == CFG_RAM_MASK) begin
        ram_mask_r <= cfg_wdata[RAMB_W-1:0];
      end
    end
  end

  // decode stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // decode stage payload; ram read data lands alongside it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= dec_kind;
      s1_rom_addr_r <= dec_rom_addr;
      s1_faddr_r <= dec_faddr;
      s1_fdata_r <= dec_fdata;
      s1_ram_rd_r <= dec_ram_rd;
      s1_ir_rd_r <= dec_ir_rd;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= s1_kind_r;
      out_rom_addr_r <= s1_rom_addr_r;
      out_faddr_r <= s1_faddr_r;
      out_fdata_r <= s1_fdata_r;
      if (s1_ir_rd_r) begin
        out_rdata_r <= IR_READ_VAL;
      end else if (s1_ram_rd_r) begin
        out_rdata_r <= ram_rdata;
      end else begin
        out_rdata_r <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_kind_r;
  assign out_ch.rom_address = out_rom_addr_r;
  assign out_ch.read_data = out_rdata_r;
  assign out_ch.forward_address = out_faddr_r;
  assign out_ch.forward_data = out_fdata_r;

`ifndef SYNTH
  // nothing enters while the ram fill is running
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ram_busy |-> !in_ch.ready)
    else $error("transaction accepted during ram fill");

  // a ram write never happens in infrared mode or during the ram fill
  a_no_ir_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> !ir_r && !ram_busy)
    else $error("ram write while infrared mode or fill");

  // read data is zero for every kind but a ram read
  a_rdata_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_RAM_READ |-> out_rdata_r == '0)
    else $error("read data set on a non-ram result");
`endif

endmodule

`default_nettype wire

@@ test/cartridge_bank_mapper_ir_top_tb.sv @@
`timescale 1ns / 100ps
// cartridge_bank_mapper_ir_top_tb: self-checking bench for the cartridge bank mapper
// depends on cbm_pkg, cbm_in_if / cbm_out_if and the cartridge_bank_mapper_ir_top rtl

module cartridge_bank_mapper_ir_top_tb;
  import cbm_pkg::*;

  // a long idle stretch is legal only during the ram fill after reset,
  // so the limit is that fill taken several times over
  localparam int WATCHDOG_CYCLES = 150000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 130;

  // one predicted result transaction
  typedef struct packed {
    cbm_kind_t kind;
    logic [ROM_AW-1:0] rom_address;
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] forward_address;
    logic [DATA_W-1:0] forward_data;
  } bus_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_WORD,
    STALL_HEAVY
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cbm_in_if in_ch ();
  cbm_out_if out_ch ();

  cartridge_bank_mapper_ir_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirror of the mapper state
  logic [DATA_W-1:0] mirror_ram [RAM_BYTES];
  logic [ROMB_W-1:0] mirror_rom_bank;
  logic [RAMB_W-1:0] mirror_ram_bank;
  logic mirror_ir;
  logic [ROMB_W-1:0] mirror_rom_mask;
  logic [RAMB_W-1:0] mirror_ram_mask;

  bus_result_t expected_results[$];

  // bookkeeping
  int error_count = 0;
  int kinds_checked [5];
  int ir_reads = 0;
  int mask_settings = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  // ram offsets that get reused so reads land on written bytes
  logic [12:0] hot_offset [8];

  // receiver pattern state
  stall_mode_t stall_mode = STALL_NONE;
  logic [31:0] stall_word;
  int stall_left = 0;

  // restore the mirror to the post-reset state
  task automatic reset_mirror();
    foreach (mirror_ram[i]) mirror_ram[i] = RAM_FILL;
    mirror_rom_bank = ROMB_RST;
    mirror_ram_bank = '0;
    mirror_ir = 1'b0;
    mirror_rom_mask = ROM_MASK_RST;
    mirror_ram_mask = RAM_MASK_RST;
  endtask

  // apply one bus access to the mirror and queue the result it should give
  task automatic predict_access(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
    bus_result_t r;
    int idx;
    r = '0;
    // bank * 0x2000 + offset, wrapped into the ram size
    idx = (int'(mirror_ram_bank) * 'h2000 + int'(addr[12:0])) % RAM_BYTES;
    if (op == OP_WRITE) begin
      r.kind = KIND_ABSORB;
      case (addr[15:13])
        RGN_MODE: mirror_ir = (data[3:0] == IR_NIBBLE);
        RGN_ROMB: mirror_rom_bank = data[ROMB_W-1:0] & mirror_rom_mask;
        RGN_RAMB: mirror_ram_bank = data[RAMB_W-1:0] & mirror_ram_mask;
        RGN_IGN: ;
        RGN_RAM: begin
          // dropped while infrared mode is on
          if (!mirror_ir) mirror_ram[idx] = data;
        end
        default: begin
          r.kind = KIND_FWD_WRITE;
          r.forward_address = addr;
          r.forward_data = data;
        end
      endcase
    end else begin
      case (addr[15:13])
        // the ram-bank-select and ignored regions form the banked rom window on reads
        RGN_RAMB, RGN_IGN: begin
          r.kind = KIND_ROM_READ;
          r.rom_address = ROM_AW'(mirror_rom_bank) * 20'h4000 + ROM_AW'(addr) - 20'h4000;
        end
        RGN_RAM: begin
          r.kind = KIND_RAM_READ;
          r.read_data = mirror_ir ? IR_READ_VAL : mirror_ram[idx];
          if (mirror_ir) ir_reads++;
        end
        default: begin
          r.kind = KIND_FWD_READ;
          r.forward_address = addr;
        end
      endcase
    end
    expected_results.push_back(r);
  endtask

  // drive one access; bursts of random length separated by random gaps
  task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      // about a quarter of the bursts follow the previous one back to back
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        in_ch.address <= ADDR_W'($urandom);
        in_ch.write_data <= DATA_W'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.address <= addr;
    in_ch.write_data <= data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_access(op, addr, data);
    burst_left--;
  endtask

  // stop sending and wait until every queued result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write both bank masks back to back; ram mask value is wider than the register
  task automatic program_masks(input logic [CFG_DATA_W-1:0] rom_mask,
                               input logic [CFG_DATA_W-1:0] ram_mask_raw);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROM_MASK;
    cfg_wdata <= rom_mask;
    @(negedge clk);
    cfg_index <= CFG_RAM_MASK;
    cfg_wdata <= ram_mask_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
    mirror_rom_mask = rom_mask[ROMB_W-1:0];
    mirror_ram_mask = ram_mask_raw[RAMB_W-1:0];
    mask_settings++;
  endtask

  // one random access, weighted toward the banked ram and bank switching
  task automatic random_access();
    int pick;
    int slot;
    logic op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, 7);
    data = DATA_W'($urandom);
    op = OP_WRITE;
    if ($urandom_range(0, 3) == 0) hot_offset[slot] = 13'($urandom);
    if (pick < 28) begin
      addr = {RGN_RAM, hot_offset[slot]};
    end else if (pick < 52) begin
      op = OP_READ;
      addr = {RGN_RAM, hot_offset[slot]};
    end else if (pick < 62) begin
      addr = {RGN_RAMB, 13'($urandom)};
    end else if (pick < 70) begin
      addr = {RGN_ROMB, 13'($urandom)};
    end else if (pick < 77) begin
      // at least half of the mode writes switch infrared mode on
      addr = {RGN_MODE, 13'($urandom)};
      if ($urandom_range(0, 1) == 1) data[3:0] = IR_NIBBLE;
    end else if (pick < 88) begin
      // rom window 0x4000-0x7fff
      op = OP_READ;
      addr = {2'b01, 14'($urandom)};
    end else begin
      // anything at all, including the ignored region and forwarded space
      op = 1'($urandom);
      addr = ADDR_W'($urandom);
    end
    send_access(op, addr, data);
  endtask

  // state right after reset, region edges, forwarding and the ignored region
  task automatic test_reset_defaults();
    send_access(OP_READ, 16'h4000, 8'h00);
    send_access(OP_READ, 16'h7FFF, 8'hFF);
    send_access(OP_READ, 16'hA000, 8'h00);
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_READ, 16'hFFFF, 8'hFF);
    send_access(OP_WRITE, 16'hC000, 8'hA5);
    send_access(OP_WRITE, 16'h6000, 8'hFF);
    send_access(OP_WRITE, 16'h7FFF, 8'h01);
  endtask

  // rom bank zero stays zero, top rom bank, ram banks at both ends
  task automatic test_bank_select();
    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_READ, 16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFF);
    send_access(OP_READ, 16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h03);
    send_access(OP_WRITE, 16'hBFFF, 8'h5A);
    send_access(OP_READ, 16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h5FFF, 8'hFC);
    send_access(OP_READ, 16'hBFFF, 8'h00);
  endtask

  // infrared reads give 0xc0, ram writes dropped, only the low nibble decides
  task automatic test_infrared_stub();
    send_access(OP_WRITE, 16'h0000, 8'h0E);
    send_access(OP_READ, 16'hA123, 8'h00);
    send_access(OP_WRITE, 16'hA123, 8'h00);
    send_access(OP_WRITE, 16'h1FFF, 8'hFE);
    send_access(OP_READ, 16'hA123, 8'h00);
    send_access(OP_WRITE, 16'h1FFF, 8'hF0);
    send_access(OP_READ, 16'hA123, 8'h00);
  endtask

  // random traffic under several mask settings, extremes included
  task automatic test_mask_phases();
    logic [CFG_DATA_W-1:0] rom_pick;
    logic [CFG_DATA_W-1:0] ram_pick;
    rom_pick = CFG_DATA_W'($urandom);
    ram_pick = CFG_DATA_W'($urandom);
    wait_idle();
    program_masks(6'h3F, 6'h03);
    repeat (PHASE_ITEMS) random_access();
    wait_idle();
    // ram mask written with upper bits set, only the low two count
    program_masks(6'h00, 6'h3C);
    repeat (PHASE_ITEMS) random_access();
    wait_idle();
    program_masks(6'h15, 6'h01);
    repeat (PHASE_ITEMS) random_access();
    wait_idle();
    program_masks(rom_pick, ram_pick);
    repeat (PHASE_ITEMS) random_access();
    wait_idle();
    program_masks(6'h3F, 6'h02);
    repeat (PHASE_ITEMS) random_access();
  endtask

  // receiver: a new random stall pattern each time the current one runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_word <= $urandom;
      stall_left <= $urandom_range(16, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_ch.ready <= 1'b1;
      STALL_COIN: out_ch.ready <= 1'($urandom);
      STALL_WORD: out_ch.ready <= stall_word[stall_left % 32];
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result transaction: kind %0d at %0t", out_ch.kind, $realtime);
      end else begin
        want = expected_results.pop_front();
        kinds_checked[int'(want.kind)]++;
        if (out_ch.kind !== want.kind || out_ch.rom_address !== want.rom_address ||
            out_ch.read_data !== want.read_data ||
            out_ch.forward_address !== want.forward_address ||
            out_ch.forward_data !== want.forward_data) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"mismatch at %0t (expected/actual): kind %0d/%0d rom %05h/%05h ",
                      "rd %02h/%02h fa %04h/%04h fd %02h/%02h"}, $realtime,
                     want.kind, out_ch.kind, want.rom_address, out_ch.rom_address,
                     want.read_data, out_ch.read_data, want.forward_address,
                     out_ch.forward_address, want.forward_data, out_ch.forward_data);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_CYCLES, expected_results.size());
      $display("FAIL cartridge_bank_mapper_ir_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_READ;
    in_ch.address = '0;
    in_ch.write_data = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROM_MASK;
    cfg_wdata = '0;
    rst_n = 1'b0;
    foreach (hot_offset[i]) hot_offset[i] = 13'($urandom);
    foreach (kinds_checked[i]) kinds_checked[i] = 0;
    reset_mirror();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first access waits out the ram fill
    test_reset_defaults();
    test_bank_select();
    test_infrared_stub();
    test_mask_phases();

    // drain, then allow the pipeline depth for any stray result
    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("%0d predicted results never arrived", expected_results.size());
    end

    $display("checked %0d rom reads, %0d ram reads (%0d in infrared mode) over %0d mask settings",
             kinds_checked[KIND_ROM_READ], kinds_checked[KIND_RAM_READ], ir_reads,
             mask_settings);
    $display("and %0d forwarded reads, %0d forwarded writes, %0d absorbed writes; %0d errors",
             kinds_checked[KIND_FWD_READ], kinds_checked[KIND_FWD_WRITE],
             kinds_checked[KIND_ABSORB], error_count);
    if (error_count == 0) begin
      $display("PASS cartridge_bank_mapper_ir_top");
    end else begin
      $display("FAIL cartridge_bank_mapper_ir_top");
    end
    $finish;
  end

endmodule
